// ----- hdl/mjsrl_pkg.sv -----
// Shared constants, codes and types for the multi-joint slew rate limiter.
package mjsrl_pkg;

    localparam int NUM_JOINTS = 20;
    localparam int JOINT_W    = 5;
    localparam int ANGLE_W    = 18;
    localparam int OPCODE_W   = 2;
    localparam int ELAPSED_W  = 12;
    localparam int RATE_W     = 16;
    localparam int STEP_SHIFT = 10;
    localparam int PROD_W     = RATE_W + ELAPSED_W;
    localparam int STEP_W     = PROD_W - STEP_SHIFT;
    localparam int CMP_W      = (STEP_W > ANGLE_W + 1) ? STEP_W + 1 : ANGLE_W + 2;

    localparam int IN_FIELDS_W  = OPCODE_W + JOINT_W + ANGLE_W + ELAPSED_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = JOINT_W + ANGLE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [RATE_W-1:0] MAX_RATE_RESET = RATE_W'(10240);

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET_GOAL  = 2'd0,
        OP_TICK      = 2'd1,
        OP_RESET_ALL = 2'd2
    } opcode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_RATE     = 1'b0,
        CFG_INSTANT_MODE = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic shift;
        logic wr_goal;
        logic wr_cur;
    } cell_ctrl_t;

endpackage

// ----- hdl/multi_joint_slew_rate_limiter.sv -----
// Top level of the multi-joint slew rate limiter: sequencer, joint ring and output stage.
//
// The joint angles live in a ring of cells, one per joint. A set-goal word is handled as
// it is accepted and, in instant mode, reports the joint at once. A tick or a reset-all
// word is handled in steps: it is accepted and the step is formed (elapsed times
// max_rate, shifted right by 10), the ring then rotates every joint once past the single
// update unit at its head, and last the final word is released with tlast (or the
// all-done word) set. Reported joints come out in index order. An input word is taken
// only while the sequencer is idle and the output register is empty or being emptied,
// so a result waiting on the master side holds off the next input word, and a stall on
// the master side while a word waits there holds the walk.
module multi_joint_slew_rate_limiter
    import mjsrl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata from bit 0: opcode, joint, goal_angle, elapsed, zero padding
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // m_tdata from bit 0: joint_out, angle_out, zero padding
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    // m_tuser: all_done
    output logic                   m_tuser,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int LSB_JOINT   = OPCODE_W;
    localparam int LSB_GOAL    = LSB_JOINT + JOINT_W;
    localparam int LSB_ELAPSED = LSB_GOAL + ANGLE_W;

    logic [OPCODE_W-1:0]  s_opcode;
    logic [JOINT_W-1:0]   s_joint;
    logic [ANGLE_W-1:0]   s_goal;
    logic [ELAPSED_W-1:0] s_elapsed;

    assign s_opcode  = s_tdata[OPCODE_W-1:0];
    assign s_joint   = s_tdata[LSB_JOINT +: JOINT_W];
    assign s_goal    = s_tdata[LSB_GOAL +: ANGLE_W];
    assign s_elapsed = s_tdata[LSB_ELAPSED +: ELAPSED_W];

    // Registers
    state_t               state_reg, state_next;
    logic [RATE_W-1:0]    max_rate_reg;
    logic                 instant_reg;
    logic [JOINT_W-1:0]   walk_idx_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 clear_reg;
    logic                 hold_vld_reg;
    logic [JOINT_W-1:0]   hold_joint_reg;
    logic [ANGLE_W-1:0]   hold_angle_reg;
    logic                 out_vld_reg;
    logic [JOINT_W-1:0]   out_joint_reg;
    logic [ANGLE_W-1:0]   out_angle_reg;
    logic                 out_last_reg;
    logic                 out_done_reg;

    // Control
    logic                 out_free;
    logic                 accept;
    logic                 set_ok;
    logic                 step_en;
    logic                 out_load;
    logic [JOINT_W-1:0]   out_joint_next;
    logic [ANGLE_W-1:0]   out_angle_next;
    logic                 out_last_next;
    logic                 out_done_next;
    logic [PROD_W-1:0]    prod;
    cell_ctrl_t           cell_ctrl [NUM_JOINTS];

    // Ring
    logic [ANGLE_W-1:0]   cell_cur  [NUM_JOINTS];
    logic [ANGLE_W-1:0]   cell_goal [NUM_JOINTS];
    logic [ANGLE_W-1:0]   upd_cur;
    logic [ANGLE_W-1:0]   upd_goal;
    logic                 upd_moved;

    assign out_free = !out_vld_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign set_ok   = accept && (s_opcode == OP_SET_GOAL)
                      && (s_joint < JOINT_W'(NUM_JOINTS));
    assign prod     = PROD_W'(s_elapsed) * PROD_W'(max_rate_reg);

    mjsrl_update u_update (
        .cur_in   (cell_cur[0]),
        .goal_in  (cell_goal[0]),
        .step     (step_reg),
        .clear    (clear_reg),
        .cur_out  (upd_cur),
        .goal_out (upd_goal),
        .moved    (upd_moved)
    );

    // Cell i takes from cell i+1; the last cell takes the updated head joint.
    for (genvar gi = 0; gi < NUM_JOINTS; gi++) begin : g_cell
        if (gi == NUM_JOINTS - 1) begin : g_tail
            mjsrl_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl[gi]),
                .shift_cur  (upd_cur),
                .shift_goal (upd_goal),
                .wr_value   (s_goal),
                .cur_q      (cell_cur[gi]),
                .goal_q     (cell_goal[gi])
            );
        end else begin : g_body
            mjsrl_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl[gi]),
                .shift_cur  (cell_cur[gi+1]),
                .shift_goal (cell_goal[gi+1]),
                .wr_value   (s_goal),
                .cur_q      (cell_cur[gi]),
                .goal_q     (cell_goal[gi])
            );
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && ((s_opcode == OP_TICK) || (s_opcode == OP_RESET_ALL))) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (step_en && (walk_idx_reg == JOINT_W'(NUM_JOINTS - 1))) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_tready       = 1'b0;
        step_en        = 1'b0;
        out_load       = 1'b0;
        out_joint_next = hold_joint_reg;
        out_angle_next = hold_angle_reg;
        out_last_next  = 1'b0;
        out_done_next  = 1'b0;
        for (int i = 0; i < NUM_JOINTS; i++) begin
            cell_ctrl[i] = '0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_tready = out_free;
                for (int i = 0; i < NUM_JOINTS; i++) begin
                    cell_ctrl[i].wr_goal = set_ok && (s_joint == JOINT_W'(i));
                    cell_ctrl[i].wr_cur  = set_ok && instant_reg
                                           && (s_joint == JOINT_W'(i));
                end
                if (set_ok && instant_reg) begin
                    out_load       = 1'b1;
                    out_joint_next = s_joint;
                    out_angle_next = s_goal;
                    out_last_next  = 1'b1;
                end
            end
            ST_WALK: begin
                step_en = out_free;
                for (int i = 0; i < NUM_JOINTS; i++) begin
                    cell_ctrl[i].shift = out_free;
                end
                // A held word is released only once a later joint proves it is not last.
                if (out_free && upd_moved && hold_vld_reg) begin
                    out_load = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    if (!hold_vld_reg) begin
                        out_joint_next = '0;
                        out_angle_next = '0;
                        out_done_next  = 1'b1;
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            max_rate_reg <= MAX_RATE_RESET;
            instant_reg  <= 1'b0;
            walk_idx_reg <= '0;
            clear_reg    <= 1'b0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MAX_RATE:     max_rate_reg <= cfg_wdata[RATE_W-1:0];
                    CFG_INSTANT_MODE: instant_reg  <= cfg_wdata[0];
                    default:          instant_reg  <= instant_reg;
                endcase
            end

            if (accept) begin
                clear_reg <= (s_opcode == OP_RESET_ALL);
            end

            if (step_en) begin
                if (walk_idx_reg == JOINT_W'(NUM_JOINTS - 1)) begin
                    walk_idx_reg <= '0;
                end else begin
                    walk_idx_reg <= walk_idx_reg + JOINT_W'(1);
                end
                if (upd_moved) begin
                    hold_vld_reg <= 1'b1;
                end
            end else if ((state_reg == ST_FINISH) && out_free) begin
                hold_vld_reg <= 1'b0;
            end

            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            step_reg <= prod[PROD_W-1:STEP_SHIFT];
        end
        if (step_en && upd_moved) begin
            hold_joint_reg <= walk_idx_reg;
            hold_angle_reg <= upd_cur;
        end
        if (out_load) begin
            out_joint_reg <= out_joint_next;
            out_angle_reg <= out_angle_next;
            out_last_reg  <= out_last_next;
            out_done_reg  <= out_done_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_TDATA_W'({out_angle_reg, out_joint_reg});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

// ----- hdl/mjsrl_cell.sv -----
// One joint cell of the rotating ring: holds a current and a goal angle.
module mjsrl_cell
    import mjsrl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl,
    input  logic [ANGLE_W-1:0] shift_cur,
    input  logic [ANGLE_W-1:0] shift_goal,
    input  logic [ANGLE_W-1:0] wr_value,
    output logic [ANGLE_W-1:0] cur_q,
    output logic [ANGLE_W-1:0] goal_q
);

    logic [ANGLE_W-1:0] cur_reg;
    logic [ANGLE_W-1:0] goal_reg;
    logic [ANGLE_W-1:0] cur_next;
    logic [ANGLE_W-1:0] goal_next;

    always_comb begin
        cur_next  = cur_reg;
        goal_next = goal_reg;
        if (ctrl.shift) begin
            cur_next  = shift_cur;
            goal_next = shift_goal;
        end else begin
            if (ctrl.wr_goal) begin
                goal_next = wr_value;
            end
            if (ctrl.wr_cur) begin
                cur_next = wr_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= '0;
            goal_reg <= '0;
        end else begin
            cur_reg  <= cur_next;
            goal_reg <= goal_next;
        end
    end

    assign cur_q  = cur_reg;
    assign goal_q = goal_reg;

endmodule

// ----- hdl/mjsrl_update.sv -----
// Update unit at the head of the ring: moves one joint towards its goal by at most one step, or clears it on reset-all.
module mjsrl_update
    import mjsrl_pkg::*;
(
    input  logic [ANGLE_W-1:0] cur_in,
    input  logic [ANGLE_W-1:0] goal_in,
    input  logic [STEP_W-1:0]  step,
    input  logic               clear,
    output logic [ANGLE_W-1:0] cur_out,
    output logic [ANGLE_W-1:0] goal_out,
    output logic               moved
);

    logic signed [CMP_W-1:0] diff;
    logic        [CMP_W-1:0] mag;
    logic        [CMP_W-1:0] step_ext;
    logic                    far;
    logic        [ANGLE_W-1:0] step_cut;

    always_comb begin
        diff     = CMP_W'($signed(goal_in)) - CMP_W'($signed(cur_in));
        mag      = diff[CMP_W-1] ? CMP_W'(-diff) : CMP_W'(diff);
        step_ext = CMP_W'(step);
        far      = mag > step_ext;
        // Only used when the step is smaller than the distance, so it fits.
        step_cut = ANGLE_W'(step);

        if (clear) begin
            cur_out  = '0;
            goal_out = '0;
            moved    = 1'b1;
        end else begin
            goal_out = goal_in;
            moved    = (cur_in != goal_in);
            if (!far) begin
                cur_out = goal_in;
            end else if (diff[CMP_W-1]) begin
                cur_out = cur_in - step_cut;
            end else begin
                cur_out = cur_in + step_cut;
            end
        end
    end

endmodule

// ----- dv/mjsrl_checker.sv -----
// Checker for the multi-joint slew rate limiter: predicts every output word and compares.
module mjsrl_checker
    import mjsrl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tlast,
    input  logic                   m_tuser,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     fail_count,
    output int                     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [JOINT_W-1:0]        joint;
        logic signed [ANGLE_W-1:0] angle;
        logic                      last;
        logic                      done;
    } joint_report_t;

    joint_report_t             reports_due[$];
    logic signed [ANGLE_W-1:0] cur_angle[NUM_JOINTS];
    logic signed [ANGLE_W-1:0] goal_angle[NUM_JOINTS];
    logic [RATE_W-1:0]         rate;
    logic                      instant;
    int                        mismatches = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic void clear_joints();
        for (int i = 0; i < NUM_JOINTS; i++) begin
            cur_angle[i]  = '0;
            goal_angle[i] = '0;
        end
    endfunction

    function automatic void report_joint(int jn, int angle, logic last, logic done);
        joint_report_t entry;
        entry.joint = JOINT_W'(jn);
        entry.angle = ANGLE_W'(angle);
        entry.last  = last;
        entry.done  = done;
        reports_due.insert(reports_due.size(), entry);
    endfunction

    // Works out the words that one accepted input word causes.
    function automatic void step_joints(logic [IN_TDATA_W-1:0] w);
        opcode_t                   op;
        logic [JOINT_W-1:0]        jn;
        logic signed [ANGLE_W-1:0] goal;
        logic [ELAPSED_W-1:0]      el;
        logic [PROD_W-1:0]         prod;
        int                        stride;
        int                        c;
        int                        t;
        int                        moved;
        op    = opcode_t'(w[OPCODE_W-1:0]);
        jn    = w[OPCODE_W +: JOINT_W];
        goal  = w[OPCODE_W + JOINT_W +: ANGLE_W];
        el    = w[OPCODE_W + JOINT_W + ANGLE_W +: ELAPSED_W];
        moved = 0;
        case (op)
            OP_SET_GOAL: begin
                if (jn < NUM_JOINTS) begin
                    goal_angle[jn] = goal;
                    if (instant) begin
                        cur_angle[jn] = goal;
                        report_joint(int'(jn), int'(goal), 1'b1, 1'b0);
                    end
                end
            end
            OP_TICK: begin
                prod   = PROD_W'(el) * PROD_W'(rate);
                stride = int'(prod >> STEP_SHIFT);
                for (int i = 0; i < NUM_JOINTS; i++) begin
                    c = int'(cur_angle[i]);
                    t = int'(goal_angle[i]);
                    if (c != t) begin
                        if (t > c)
                            c = (t - c > stride) ? c + stride : t;
                        else
                            c = (c - t > stride) ? c - stride : t;
                        cur_angle[i] = ANGLE_W'(c);
                        report_joint(i, c, 1'b0, 1'b0);
                        moved++;
                    end
                end
                if (moved == 0)
                    report_joint(0, 0, 1'b1, 1'b1);
                else
                    reports_due[reports_due.size() - 1].last = 1'b1;
            end
            OP_RESET_ALL: begin
                clear_joints();
                for (int i = 0; i < NUM_JOINTS; i++)
                    report_joint(i, 0, i == NUM_JOINTS - 1, 1'b0);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    function automatic void check_report();
        joint_report_t due;
        if (reports_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected output word, expected none, actual joint %0d angle %0d",
                     $time, m_tdata[JOINT_W-1:0], $signed(m_tdata[JOINT_W +: ANGLE_W]));
        end else begin
            due = reports_due.pop_front();
            check_field("joint_out", int'(due.joint), int'(m_tdata[JOINT_W-1:0]));
            check_field("angle_out", int'(due.angle),
                        int'($signed(m_tdata[JOINT_W +: ANGLE_W])));
            check_field("tlast", int'(due.last), int'(m_tlast));
            check_field("all_done", int'(due.done), int'(m_tuser));
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_joints();
            rate    = MAX_RATE_RESET;
            instant = 1'b0;
            reports_due.delete();
        end else begin
            // Output words belong to earlier input words, so they are checked first.
            if (m_tvalid && m_tready)
                check_report();
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    CFG_MAX_RATE:     rate    = cfg_wdata[RATE_W-1:0];
                    CFG_INSTANT_MODE: instant = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                step_joints(s_tdata);
        end
        fail_count    <= mismatches;
        pending_count <= reports_due.size();
    end

endmodule

// ----- dv/tb_multi_joint_slew_rate_limiter.sv -----
// Testbench top for the multi-joint slew rate limiter: stimulus, flow control and verdict.
module tb_multi_joint_slew_rate_limiter;
    import mjsrl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE      = NUM_JOINTS + 4;
    localparam int IDLE_LIMIT  = 5000;
    localparam int NUM_PHASES  = 7;
    localparam int PHASE_ITEMS = 50;
    localparam int ANGLE_TOP   = 131071;
    localparam int ANGLE_BOT   = -131072;
    localparam int ELAPSED_TOP = 4095;

    typedef enum int {RX_OPEN, RX_COIN, RX_CHOKED} rx_mode_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    int                     fail_count;
    int                     pending_count;

    int       burst_left  = 0;
    int       mode_left   = 0;
    rx_mode_t rx_mode     = RX_OPEN;
    int       idle_cycles = 0;

    always #5 aclk = ~aclk;

    multi_joint_slew_rate_limiter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    mjsrl_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // The receiver switches between always ready, coin toss and mostly stalled.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 2));
            mode_left <= $urandom_range(16, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("** multi_joint_slew_rate_limiter: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] make_word(logic [OPCODE_W-1:0] op, int jn,
                                                       int goal, int el);
        return IN_TDATA_W'({ELAPSED_W'(el), ANGLE_W'(goal), JOINT_W'(jn), op});
    endfunction

    // Drives one word and holds it until taken; bursts end in a random gap, which may be zero.
    task automatic send_word(input logic [IN_TDATA_W-1:0] w);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Waits until every expected word is out and the ring has come to rest.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_count == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_regs(input int rate, input int instant);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_MAX_RATE;
        cfg_wdata <= CFG_DATA_W'(rate);
        @(posedge aclk);
        cfg_addr  <= CFG_INSTANT_MODE;
        cfg_wdata <= CFG_DATA_W'(instant);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int pick_goal();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 1) ? ANGLE_TOP : ANGLE_BOT;
            2, 3, 4: return $urandom_range(0, 4000) - 2000;
            default: return int'($signed(ANGLE_W'($urandom)));
        endcase
    endfunction

    function automatic int pick_elapsed();
        case ($urandom_range(0, 19))
            0, 1, 2:       return $urandom_range(0, 1) ? ELAPSED_TOP : 0;
            3, 4, 5, 6, 7: return $urandom_range(0, ELAPSED_TOP);
            default:       return $urandom_range(0, 63);
        endcase
    endfunction

    // Mostly goal writes and ticks; a few resets and words the block ignores.
    task automatic random_item(output bit counted);
        int pick;
        pick    = $urandom_range(0, 99);
        counted = 1'b1;
        if (pick < 45) begin
            send_word(make_word(OP_SET_GOAL, $urandom_range(0, NUM_JOINTS - 1),
                                pick_goal(), $urandom_range(0, ELAPSED_TOP)));
        end else if (pick < 83) begin
            send_word(make_word(OP_TICK, $urandom_range(0, 31), int'($urandom),
                                pick_elapsed()));
        end else if (pick < 87) begin
            send_word(make_word(OP_RESET_ALL, $urandom_range(0, 31), int'($urandom),
                                $urandom_range(0, ELAPSED_TOP)));
        end else if (pick < 93) begin
            counted = 1'b0;
            send_word(make_word(OP_UNUSED, $urandom_range(0, 31), int'($urandom),
                                $urandom_range(0, ELAPSED_TOP)));
        end else begin
            counted = 1'b0;
            send_word(make_word(OP_SET_GOAL, $urandom_range(NUM_JOINTS, 31), pick_goal(),
                                $urandom_range(0, ELAPSED_TOP)));
        end
    endtask

    initial begin
        int rates[NUM_PHASES];
        int modes[NUM_PHASES];
        int done_items;
        bit counted;
        rates = '{10240, 65535, 0, 1, 0, 0, 4096};
        modes = '{0, 0, 0, 1, 1, 0, 1};
        rates[4] = $urandom_range(0, 65535);
        rates[5] = $urandom_range(0, 65535);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register values from reset: all done, ignored words, zero and full steps.
        send_word(make_word(OP_TICK, 0, 0, 5));
        send_word(make_word(OP_UNUSED, 7, 12345, 99));
        send_word(make_word(OP_SET_GOAL, 0, ANGLE_TOP, 0));
        send_word(make_word(OP_SET_GOAL, NUM_JOINTS - 1, ANGLE_BOT, 0));
        send_word(make_word(OP_SET_GOAL, NUM_JOINTS, 1000, 0));
        send_word(make_word(OP_SET_GOAL, 31, -1, 0));
        send_word(make_word(OP_TICK, 0, 0, 0));
        send_word(make_word(OP_TICK, 0, 0, ELAPSED_TOP));
        send_word(make_word(OP_TICK, 0, 0, 1));
        send_word(make_word(OP_RESET_ALL, 0, 0, 0));
        send_word(make_word(OP_TICK, 0, 0, ELAPSED_TOP));
        drain();

        write_regs(65535, 1);
        send_word(make_word(OP_SET_GOAL, 5, ANGLE_BOT, 0));
        send_word(make_word(OP_SET_GOAL, NUM_JOINTS - 1, ANGLE_TOP, 0));
        send_word(make_word(OP_SET_GOAL, 31, 42, 0));
        send_word(make_word(OP_TICK, 0, 0, ELAPSED_TOP));
        drain();

        // The largest step covers most of the range but not the full swing.
        write_regs(65535, 0);
        send_word(make_word(OP_SET_GOAL, 0, ANGLE_TOP, 0));
        send_word(make_word(OP_SET_GOAL, 1, ANGLE_BOT, 0));
        send_word(make_word(OP_SET_GOAL, 2, 300, 0));
        send_word(make_word(OP_TICK, 0, 0, ELAPSED_TOP));
        send_word(make_word(OP_SET_GOAL, 0, ANGLE_BOT, 0));
        send_word(make_word(OP_TICK, 0, 0, ELAPSED_TOP));
        send_word(make_word(OP_TICK, 0, 0, ELAPSED_TOP));
        drain();

        write_regs(0, 0);
        send_word(make_word(OP_SET_GOAL, 3, 77, 0));
        send_word(make_word(OP_TICK, 0, 0, ELAPSED_TOP));
        send_word(make_word(OP_RESET_ALL, 0, 0, 0));
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_regs(rates[p], modes[p]);
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                random_item(counted);
                if (counted)
                    done_items++;
            end
            drain();
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("** multi_joint_slew_rate_limiter: PASSED **");
        end else begin
            $display("** multi_joint_slew_rate_limiter: FAILED **");
        end
        $finish;
    end

endmodule
